// File: src/max_heap_insert_position_query_top_defines.svh
// ----------------------------------------------------------------------------
// max_heap_insert_position_query_top_defines
// assertion macros for the heap insert and position query block
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_INSERT_POSITION_QUERY_TOP_DEFINES_SVH
`define MAX_HEAP_INSERT_POSITION_QUERY_TOP_DEFINES_SVH

`ifndef SYNTH
`define MHIPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mhipq assertion failed");
`define MHIPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhipq implication failed");
`else
`define MHIPQ_ASSERT(lbl, clk, rst_n, prop)
`define MHIPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: src/mhipq_pkg.sv
// ----------------------------------------------------------------------------
// mhipq_pkg
// shared types and constants of the heap insert and position query block
// ----------------------------------------------------------------------------
package mhipq_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int ARR_W    = 11;
    localparam int STATUS_W = 3;
    localparam int LEVEL_W  = 4;
    localparam int POS_W    = 11;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_FOUND     = 3'd1;
    localparam t_status ST_NOT_FOUND = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_CLEARED   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_PLACE,
        S_QWAIT,
        S_LEVEL,
        S_DONE
    } t_state;

endpackage

// File: src/mhipq_level.sv
// ----------------------------------------------------------------------------
// mhipq_level
// iterative shifter turning a heap slot into its level and position in level
// ----------------------------------------------------------------------------
module mhipq_level #(
    parameter int AW = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [AW-1:0]                   i_slot,
    output logic                            o_done,
    output logic [mhipq_pkg::LEVEL_W-1:0]   o_level,
    output logic [mhipq_pkg::POS_W-1:0]     o_position
);

    localparam int NW  = AW + 1;
    localparam int LVW = $clog2(AW + 2);

    logic           r_busy;
    logic           r_done;
    logic [NW-1:0]  r_n;
    logic [NW-1:0]  r_work;
    logic [NW-1:0]  r_first;
    logic [LVW-1:0] r_level;

    logic [NW-1:0]                        w_pos;
    logic [NW+mhipq_pkg::POS_W-1:0]       w_pos_ext;
    logic [LVW+mhipq_pkg::LEVEL_W-1:0]    w_lvl_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_work <= NW'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n     <= NW'(i_slot) + NW'(1);
            r_work  <= NW'(i_slot) + NW'(1);
            r_first <= NW'(1);
            r_level <= LVW'(1);
        end else if (r_busy && (r_work > NW'(1))) begin
            r_work  <= r_work >> 1;
            r_first <= r_first << 1;
            r_level <= r_level + LVW'(1);
        end
    end

    assign w_pos      = r_n - r_first + NW'(1);
    assign w_pos_ext  = {{mhipq_pkg::POS_W{1'b0}}, w_pos};
    assign w_lvl_ext  = {{mhipq_pkg::LEVEL_W{1'b0}}, r_level};
    assign o_done     = r_done;
    assign o_level    = w_lvl_ext[mhipq_pkg::LEVEL_W-1:0];
    assign o_position = w_pos_ext[mhipq_pkg::POS_W-1:0];

endmodule

// File: src/max_heap_insert_position_query_top.sv
// ----------------------------------------------------------------------------
// max_heap_insert_position_query_top
// binary max-heap with arrival tags; insert, position query and clear
// ----------------------------------------------------------------------------
// Keys and tags live in two memories indexed by heap slot, and a third
// memory maps each arrival number to its current heap slot, so a query
// needs no search. An insert walks up from the new slot: for each parent
// it reads the parent, then compares and moves it down when it is
// smaller; the walk ends at the first parent that is not smaller or at
// the root, and the key and tag are then placed. A query that finds its
// entry reads the slot of its arrival number and waits for the shifter
// that derives level and position from the slot. Clear, refused inserts,
// queries that miss and unknown kinds go straight to the done state. One
// transaction is worked on at a time; the result sits in an output
// register, and the next transaction is taken while it waits. A finished
// result that finds the output register still held stays in the done
// state until it can move over. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "max_heap_insert_position_query_top_defines.svh"

module max_heap_insert_position_query_top #(
    parameter int CAPACITY = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mhipq_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [mhipq_pkg::KEY_W-1:0]  i_value,
    input  logic [mhipq_pkg::ARR_W-1:0]         i_arrival_number,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mhipq_pkg::STATUS_W-1:0]      o_status,
    output logic [mhipq_pkg::LEVEL_W-1:0]       o_level,
    output logic [mhipq_pkg::POS_W-1:0]         o_position_in_level
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int QW = (CW > mhipq_pkg::ARR_W) ? CW : mhipq_pkg::ARR_W;

    mhipq_pkg::t_state r_state;
    mhipq_pkg::t_state n_state;

    logic [CW-1:0]                      r_count;
    logic signed [mhipq_pkg::KEY_W-1:0] r_key;
    logic [CW-1:0]                      r_tag;
    logic [AW-1:0]                      r_slot;
    logic [AW-1:0]                      r_parent;

    mhipq_pkg::t_status                 r_res_status;
    logic [mhipq_pkg::LEVEL_W-1:0]      r_res_level;
    logic [mhipq_pkg::POS_W-1:0]        r_res_pos;

    logic                               r_out_valid;
    mhipq_pkg::t_status                 r_out_status;
    logic [mhipq_pkg::LEVEL_W-1:0]      r_out_level;
    logic [mhipq_pkg::POS_W-1:0]        r_out_pos;

    logic signed [mhipq_pkg::KEY_W-1:0] r_heap_keys [CAPACITY];
    logic [CW-1:0]                      r_heap_tags [CAPACITY];
    logic [AW-1:0]                      r_slot_of_tag [CAPACITY];
    logic signed [mhipq_pkg::KEY_W-1:0] r_rd_key;
    logic [CW-1:0]                      r_rd_tag;
    logic [AW-1:0]                      r_rd_slot;

    logic                               w_in_accept;
    logic                               w_full;
    logic [QW-1:0]                      w_want;
    logic [QW-1:0]                      w_count_q;
    logic                               w_query_hit;
    logic [AW-1:0]                      w_want_idx;
    logic [AW-1:0]                      w_parent;
    logic                               w_key_less;

    logic                               w_heap_we;
    logic signed [mhipq_pkg::KEY_W-1:0] w_wr_key;
    logic [CW-1:0]                      w_wr_tag;
    logic [AW-1:0]                      w_pos_addr;
    logic                               w_lvl_start;
    logic                               w_out_load;

    logic                               w_lvl_done;
    logic [mhipq_pkg::LEVEL_W-1:0]      w_lvl_level;
    logic [mhipq_pkg::POS_W-1:0]        w_lvl_pos;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_want      = QW'(i_arrival_number);
    assign w_count_q   = QW'(r_count);
    assign w_query_hit = (w_want != '0) && (w_want <= w_count_q);
    assign w_want_idx  = AW'(w_want - QW'(1));
    assign w_parent    = AW'((r_slot - AW'(1)) >> 1);
    assign w_key_less  = (r_rd_key < r_key);
    assign w_pos_addr  = AW'(w_wr_tag - CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mhipq_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    case (i_kind)
                        mhipq_pkg::KIND_INSERT: begin
                            if (w_full) begin
                                n_state = mhipq_pkg::S_DONE;
                            end else if (r_count == '0) begin
                                n_state = mhipq_pkg::S_PLACE;
                            end else begin
                                n_state = mhipq_pkg::S_READ;
                            end
                        end
                        mhipq_pkg::KIND_QUERY: begin
                            n_state = w_query_hit ? mhipq_pkg::S_QWAIT : mhipq_pkg::S_DONE;
                        end
                        default: begin
                            n_state = mhipq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            mhipq_pkg::S_READ: begin
                n_state = mhipq_pkg::S_CMP;
            end
            mhipq_pkg::S_CMP: begin
                if (w_key_less && (r_parent != '0)) begin
                    n_state = mhipq_pkg::S_READ;
                end else begin
                    n_state = mhipq_pkg::S_PLACE;
                end
            end
            mhipq_pkg::S_PLACE: begin
                n_state = mhipq_pkg::S_DONE;
            end
            mhipq_pkg::S_QWAIT: begin
                n_state = mhipq_pkg::S_LEVEL;
            end
            mhipq_pkg::S_LEVEL: begin
                if (w_lvl_done) begin
                    n_state = mhipq_pkg::S_DONE;
                end
            end
            mhipq_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = mhipq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhipq_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_heap_we   = 1'b0;
        w_wr_key    = r_key;
        w_wr_tag    = r_tag;
        w_lvl_start = 1'b0;
        w_out_load  = 1'b0;
        o_in_stall  = 1'b1;
        case (r_state)
            mhipq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            mhipq_pkg::S_CMP: begin
                w_heap_we = w_key_less;
                w_wr_key  = r_rd_key;
                w_wr_tag  = r_rd_tag;
            end
            mhipq_pkg::S_PLACE: begin
                w_heap_we = 1'b1;
            end
            mhipq_pkg::S_QWAIT: begin
                w_lvl_start = 1'b1;
            end
            mhipq_pkg::S_DONE: begin
                w_out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                w_heap_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_heap_we) begin
            r_heap_keys[r_slot] <= w_wr_key;
            r_heap_tags[r_slot] <= w_wr_tag;
            r_slot_of_tag[w_pos_addr] <= r_slot;
        end
        r_rd_key  <= r_heap_keys[w_parent];
        r_rd_tag  <= r_heap_tags[w_parent];
        r_rd_slot <= r_slot_of_tag[w_want_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhipq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_accept) begin
                if ((i_kind == mhipq_pkg::KIND_INSERT) && !w_full) begin
                    r_count <= r_count + CW'(1);
                end else if (i_kind == mhipq_pkg::KIND_CLEAR) begin
                    r_count <= '0;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_key       <= i_value;
            r_tag       <= r_count + CW'(1);
            r_slot      <= AW'(r_count);
            r_res_level <= '0;
            r_res_pos   <= '0;
            case (i_kind)
                mhipq_pkg::KIND_INSERT: begin
                    r_res_status <= w_full ? mhipq_pkg::ST_FULL : mhipq_pkg::ST_INSERTED;
                end
                mhipq_pkg::KIND_CLEAR: begin
                    r_res_status <= mhipq_pkg::ST_CLEARED;
                end
                default: begin
                    r_res_status <= mhipq_pkg::ST_NOT_FOUND;
                end
            endcase
        end
        if (r_state == mhipq_pkg::S_READ) begin
            r_parent <= w_parent;
        end
        if ((r_state == mhipq_pkg::S_CMP) && w_key_less) begin
            r_slot <= r_parent;
        end
        if ((r_state == mhipq_pkg::S_LEVEL) && w_lvl_done) begin
            r_res_status <= mhipq_pkg::ST_FOUND;
            r_res_level  <= w_lvl_level;
            r_res_pos    <= w_lvl_pos;
        end
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_level  <= r_res_level;
            r_out_pos    <= r_res_pos;
        end
    end

    mhipq_level #(
        .AW (AW)
    ) u_level (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_lvl_start),
        .i_slot     (r_rd_slot),
        .o_done     (w_lvl_done),
        .o_level    (w_lvl_level),
        .o_position (w_lvl_pos)
    );

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_level             = r_out_level;
    assign o_position_in_level = r_out_pos;

    `MHIPQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, w_in_accept |=> (r_state != mhipq_pkg::S_IDLE))
    `MHIPQ_ASSERT_IMPL(a_lvl_done_in_level, i_clk, i_rst_n, w_lvl_done, r_state == mhipq_pkg::S_LEVEL)
    `MHIPQ_ASSERT(a_clear_empties, i_clk, i_rst_n, (w_in_accept && (i_kind == mhipq_pkg::KIND_CLEAR)) |=> (r_count == '0))
    `MHIPQ_ASSERT_IMPL(a_place_nonempty, i_clk, i_rst_n, r_state == mhipq_pkg::S_PLACE, r_count != '0)

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the heap insert and position query block against a heap kept in
// the bench: directed corners, a fill past capacity, random sets, back-pressure
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 1024;
    localparam logic [mhipq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        mhipq_pkg::t_status                 status;
        logic [mhipq_pkg::LEVEL_W-1:0]      level;
        logic [mhipq_pkg::POS_W-1:0]        pos;
    } t_answer;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n;
    logic                                   i_in_valid;
    logic                                   o_in_stall;
    logic [mhipq_pkg::KIND_W-1:0]           i_kind;
    logic signed [mhipq_pkg::KEY_W-1:0]     i_value;
    logic [mhipq_pkg::ARR_W-1:0]            i_arrival_number;
    logic                                   o_out_valid;
    logic                                   i_out_stall;
    logic [mhipq_pkg::STATUS_W-1:0]         o_status;
    logic [mhipq_pkg::LEVEL_W-1:0]          o_level;
    logic [mhipq_pkg::POS_W-1:0]            o_position_in_level;

    // heap image kept by the bench
    logic signed [mhipq_pkg::KEY_W-1:0]     heap_key [CAPACITY];
    logic [mhipq_pkg::ARR_W-1:0]            heap_tag [CAPACITY];
    int                                     heap_count;

    t_answer                                answer_q[$];
    t_answer                                head_answer;
    int                                     mismatch_count;
    int                                     sent_count;
    int                                     idle_pct;
    int                                     hold_cycles;
    int                                     stall_left;

    max_heap_insert_position_query_top #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_kind              (i_kind),
        .i_value             (i_value),
        .i_arrival_number    (i_arrival_number),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_level             (o_level),
        .o_position_in_level (o_position_in_level)
    );

    always #2 i_clk = ~i_clk;

    // applies one transaction to the heap image and returns its answer
    function automatic t_answer heap_apply(logic [mhipq_pkg::KIND_W-1:0] kind,
                                           logic signed [mhipq_pkg::KEY_W-1:0] value,
                                           logic [mhipq_pkg::ARR_W-1:0] arrival);
        t_answer                            ans;
        int                                 slot;
        int                                 parent;
        int                                 n;
        int                                 msb;
        logic signed [mhipq_pkg::KEY_W-1:0] k;
        logic [mhipq_pkg::ARR_W-1:0]        t;
        ans = '{status: mhipq_pkg::ST_NOT_FOUND, level: '0, pos: '0};
        if (kind == mhipq_pkg::KIND_INSERT) begin
            if (heap_count >= CAPACITY) begin
                ans.status = mhipq_pkg::ST_FULL;
            end else begin
                slot = heap_count;
                heap_key[slot] = value;
                heap_tag[slot] = mhipq_pkg::ARR_W'(heap_count + 1);
                heap_count++;
                while (slot > 0) begin
                    parent = (slot - 1) / 2;
                    if (!(heap_key[parent] < heap_key[slot])) break;
                    k = heap_key[parent];
                    t = heap_tag[parent];
                    heap_key[parent] = heap_key[slot];
                    heap_tag[parent] = heap_tag[slot];
                    heap_key[slot] = k;
                    heap_tag[slot] = t;
                    slot = parent;
                end
                ans.status = mhipq_pkg::ST_INSERTED;
            end
        end else if (kind == mhipq_pkg::KIND_QUERY) begin
            for (int i = 0; i < heap_count; i++) begin
                if (heap_tag[i] == arrival) begin
                    n = i + 1;
                    msb = 0;
                    for (int b = 0; b < 31; b++) begin
                        if (n[b]) msb = b;
                    end
                    ans.status = mhipq_pkg::ST_FOUND;
                    ans.level = mhipq_pkg::LEVEL_W'(msb + 1);
                    ans.pos = mhipq_pkg::POS_W'(n - (1 << msb) + 1);
                    break;
                end
            end
        end else if (kind == mhipq_pkg::KIND_CLEAR) begin
            heap_count = 0;
            ans.status = mhipq_pkg::ST_CLEARED;
        end
        return ans;
    endfunction

    task automatic send_item(logic [mhipq_pkg::KIND_W-1:0] kind,
                             logic signed [mhipq_pkg::KEY_W-1:0] value,
                             logic [mhipq_pkg::ARR_W-1:0] arrival);
        int      gap;
        t_answer exp_ans;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_value <= value;
        i_arrival_number <= arrival;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        exp_ans = heap_apply(kind, value, arrival);
        answer_q.insert(answer_q.size(), exp_ans);
        sent_count++;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [mhipq_pkg::KEY_W-1:0] pick_key(bit narrow);
        if (narrow) return mhipq_pkg::KEY_W'(int'($urandom_range(0, 6)) - 3);
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly arrival numbers that exist, sometimes zero, the next unused one or a random one
    function automatic logic [mhipq_pkg::ARR_W-1:0] pick_arrival();
        if (heap_count > 0 && $urandom_range(0, 9) < 8) begin
            return mhipq_pkg::ARR_W'($urandom_range(1, heap_count));
        end
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return mhipq_pkg::ARR_W'(heap_count + 1);
            default: return mhipq_pkg::ARR_W'($urandom);
        endcase
    endfunction

    task automatic send_query();
        send_item(mhipq_pkg::KIND_QUERY, $urandom, pick_arrival());
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0:       send_item(KIND_UNUSED, $urandom, mhipq_pkg::ARR_W'($urandom));
            1:       send_item(mhipq_pkg::KIND_QUERY, $urandom, mhipq_pkg::ARR_W'($urandom));
            default: send_item(mhipq_pkg::KIND_QUERY, $urandom, '0);
        endcase
    endtask

    task automatic test_directed();
        idle_pct = 0;
        send_item(mhipq_pkg::KIND_QUERY, 32'sd0, 11'd1);
        send_item(mhipq_pkg::KIND_QUERY, 32'sd0, 11'd0);
        send_item(KIND_UNUSED, -32'sd1, 11'h7FF);
        send_item(mhipq_pkg::KIND_INSERT, 32'sd0, 11'd0);
        send_item(mhipq_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 11'h7FF);
        send_item(mhipq_pkg::KIND_INSERT, 32'sh8000_0000, 11'd0);
        send_item(mhipq_pkg::KIND_INSERT, -32'sd1, 11'd0);
        send_item(mhipq_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 11'd0);
        send_item(mhipq_pkg::KIND_INSERT, 32'sd1, 11'd0);
        for (int a = 1; a <= 7; a++) begin
            send_item(mhipq_pkg::KIND_QUERY, 32'sd0, mhipq_pkg::ARR_W'(a));
        end
        send_item(mhipq_pkg::KIND_QUERY, 32'sd0, 11'h7FF);
        send_item(mhipq_pkg::KIND_QUERY, 32'sd0, 11'd1024);
        send_item(mhipq_pkg::KIND_CLEAR, 32'sd0, 11'd0);
        send_item(mhipq_pkg::KIND_QUERY, 32'sd0, 11'd1);
        send_item(mhipq_pkg::KIND_INSERT, -32'sd5, 11'd0);
        send_item(mhipq_pkg::KIND_QUERY, 32'sd0, 11'd1);
        send_item(mhipq_pkg::KIND_QUERY, 32'sd0, 11'd2);
    endtask

    task automatic test_long_hold();
        idle_pct = 0;
        @(posedge i_clk);
        hold_cycles = 300;
        for (int j = 0; j < 40; j++) begin
            if (j % 4 == 3) send_query();
            else send_item(mhipq_pkg::KIND_INSERT, pick_key(1'b0), mhipq_pkg::ARR_W'($urandom));
        end
    endtask

    task automatic test_fill_to_capacity();
        idle_pct = 10;
        send_item(mhipq_pkg::KIND_CLEAR, $urandom, mhipq_pkg::ARR_W'($urandom));
        while (heap_count < CAPACITY) begin
            if ($urandom_range(0, 7) == 0) begin
                send_query();
            end else begin
                send_item(mhipq_pkg::KIND_INSERT, pick_key($urandom_range(0, 3) == 0),
                          mhipq_pkg::ARR_W'($urandom));
            end
        end
        repeat (4) send_item(mhipq_pkg::KIND_INSERT, pick_key(1'b0), mhipq_pkg::ARR_W'($urandom));
        send_item(mhipq_pkg::KIND_QUERY, $urandom, 11'd1);
        send_item(mhipq_pkg::KIND_QUERY, $urandom, 11'd1024);
        send_item(mhipq_pkg::KIND_QUERY, $urandom, 11'd1025);
        send_item(mhipq_pkg::KIND_QUERY, $urandom, 11'h7FF);
        send_item(mhipq_pkg::KIND_QUERY, $urandom, 11'd0);
        repeat (6) send_query();
    endtask

    task automatic test_random_sets();
        int  set_size;
        int  inserted;
        bit  narrow;
        int  roll;
        while (sent_count < 1490) begin
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
            send_item(mhipq_pkg::KIND_CLEAR, $urandom, mhipq_pkg::ARR_W'($urandom));
            set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 24);
            narrow = $urandom_range(0, 1);
            inserted = 0;
            while (inserted < set_size) begin
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    send_item(mhipq_pkg::KIND_INSERT, pick_key(narrow),
                              mhipq_pkg::ARR_W'($urandom));
                    inserted++;
                end else if (roll < 92) begin
                    send_query();
                end else begin
                    send_noise();
                end
            end
            repeat ($urandom_range(1, 6)) send_query();
        end
    endtask

    task automatic test_calm_tail();
        idle_pct = 0;
        send_item(mhipq_pkg::KIND_CLEAR, $urandom, mhipq_pkg::ARR_W'($urandom));
        for (int j = 0; j < 60; j++) begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    send_item(mhipq_pkg::KIND_INSERT, pick_key(j[0]),
                              mhipq_pkg::ARR_W'($urandom));
                end
                2, 3:    send_query();
                default: send_noise();
            endcase
        end
    endtask

    task automatic note_fault(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answer_q.size() == 0) begin
                note_fault($sformatf("unexpected transaction: status %0d level %0d pos %0d",
                                     o_status, o_level, o_position_in_level));
            end else begin
                head_answer = answer_q.pop_front();
                if (o_status !== head_answer.status || o_level !== head_answer.level ||
                    o_position_in_level !== head_answer.pos) begin
                    note_fault($sformatf(
                        "mismatch: status %0d/%0d level %0d/%0d pos %0d/%0d (exp/act)",
                        head_answer.status, o_status, head_answer.level, o_level,
                        head_answer.pos, o_position_in_level));
                end
            end
        end
    end

    // receiver stall
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = mhipq_pkg::KIND_INSERT;
        i_value = '0;
        i_arrival_number = '0;
        heap_count = 0;
        mismatch_count = 0;
        sent_count = 0;
        idle_pct = 0;
        hold_cycles = 0;
        stall_left = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_long_hold();
        test_fill_to_capacity();
        test_random_sets();
        test_calm_tail();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
